// File: design/kmc_pkg.sv
// shared types and constants for the k-means engine
`timescale 1ns / 1ps
package kmc_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 8;
  localparam int COORD_W      = 16;
  localparam int PI_W         = 10;
  localparam int CI_W         = 4;
  localparam int DI_W         = 3;
  localparam int SUM_W        = 26;
  localparam int CNT_W        = 11;
  localparam int DIST_W       = 35;
  localparam int SQ_W         = 32;
  localparam int PASS_W       = 15;
  localparam int THR_W        = 16;
  localparam int PROD_W       = 27;
  localparam int DIV_STEPS    = 26;
  localparam int DIVC_W       = 5;

  localparam logic [PASS_W-1:0] PASS_LIMIT = 15'h7fff;

  localparam logic [4:0]  RST_CLUSTERS  = 5'd2;
  localparam logic [3:0]  RST_DIMS      = 4'd2;
  localparam logic [10:0] RST_POINTS    = 11'd1024;
  localparam logic [15:0] RST_THRESHOLD = 16'd3277;

  // configuration register indexes
  localparam logic [1:0] REG_CLUSTERS  = 2'd0;
  localparam logic [1:0] REG_DIMS      = 2'd1;
  localparam logic [1:0] REG_POINTS    = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD       = 2'd0,
    OP_RUN        = 2'd1,
    OP_READ_LABEL = 2'd2,
    OP_READ_CENT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_UNASSIGNED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OUT_ZERO  = 2'd0,
    OUT_LABEL = 2'd1,
    OUT_CENT  = 2'd2,
    OUT_RUN   = 2'd3
  } out_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_LABEL, S_RD_CENT, S_SEED_RD, S_SEED_WR, S_PASS_INIT,
    S_DIST_RD, S_DIST_SQ, S_DIST_ACC, S_BEST, S_LBL_RD, S_LBL_UPD,
    S_SUM_RD, S_SUM_WR, S_MEAN_START, S_MEAN_RD, S_MEAN_DIV, S_MEAN_WAIT,
    S_MEAN_NEXT, S_CHECK, S_DONE
  } state_t;

  typedef struct packed {
    logic     load_wr;
    logic     host_rd;
    logic     out_ld;
    out_sel_t out_sel;
    logic     run_init;
    logic     c_clr;
    logic     c_inc;
    logic     j_clr;
    logic     j_inc;
    logic     p_clr;
    logic     p_inc;
    logic     seed_rd;
    logic     seed_wr;
    logic     pass_init;
    logic     pass_end;
    logic     dist_rd;
    logic     dist_sq;
    logic     dist_acc;
    logic     dist_clr;
    logic     best_upd;
    logic     lbl_rd;
    logic     lbl_upd;
    logic     sum_rd;
    logic     sum_wr;
    logic     mean_rd;
    logic     div_start;
    logic     mean_wr;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic c_last;
    logic p_last;
    logic cnt_zero;
    logic div_done;
    logic more_passes;
  } sts_t;

endpackage

// File: design/kmc_div.sv
// iterative restoring divider, signed sum by unsigned member count
`timescale 1ns / 1ps
module kmc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [kmc_pkg::SUM_W-1:0]  dividend,
  input  logic [kmc_pkg::CNT_W-1:0]         divisor,
  output logic                              done,
  output logic signed [kmc_pkg::COORD_W-1:0] quotient
);

  logic [kmc_pkg::SUM_W-1:0]  quo;
  logic [kmc_pkg::CNT_W-1:0]  rem;
  logic [kmc_pkg::CNT_W-1:0]  dvs;
  logic                       neg;
  logic                       busy;
  logic [kmc_pkg::DIVC_W-1:0] cnt;
  logic [kmc_pkg::CNT_W:0]    shifted;
  logic [kmc_pkg::CNT_W:0]    trial;
  logic [kmc_pkg::SUM_W-1:0]  neg_quo;

  assign shifted = {rem, quo[kmc_pkg::SUM_W-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign neg_quo = -quo;
  assign quotient = neg ? neg_quo[kmc_pkg::COORD_W-1:0] : quo[kmc_pkg::COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= kmc_pkg::DIVC_W'(kmc_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[kmc_pkg::SUM_W-1];
      quo <= dividend[kmc_pkg::SUM_W-1] ? -dividend : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[kmc_pkg::CNT_W]) begin
        rem <= trial[kmc_pkg::CNT_W-1:0];
        quo <= {quo[kmc_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[kmc_pkg::CNT_W-1:0];
        quo <= {quo[kmc_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: design/kmc_datapath.sv
// stores, distance unit, accumulators and configuration of the k-means engine
`timescale 1ns / 1ps
module kmc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  kmc_pkg::cmd_t                      cmd,
  output kmc_pkg::sts_t                      sts,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data,
  input  logic [kmc_pkg::PI_W-1:0]           in_pi,
  input  logic [kmc_pkg::CI_W-1:0]           in_ci,
  input  logic [kmc_pkg::DI_W-1:0]           in_di,
  input  logic signed [kmc_pkg::COORD_W-1:0] in_coord,
  output logic signed [kmc_pkg::COORD_W-1:0] out_value,
  output kmc_pkg::status_t                   out_status
);

  localparam int PA_W = kmc_pkg::PI_W + kmc_pkg::DI_W;
  localparam int CA_W = kmc_pkg::CI_W + kmc_pkg::DI_W;
  localparam int CE_N = kmc_pkg::MAX_CLUSTERS * kmc_pkg::MAX_DIMS;

  // configuration
  logic [4:0]  cfg_k;
  logic [3:0]  cfg_d;
  logic [10:0] cfg_n;
  logic [15:0] cfg_thr;
  logic [kmc_pkg::CI_W-1:0] k_m1;
  logic [kmc_pkg::DI_W-1:0] d_m1;
  logic [kmc_pkg::PI_W-1:0] n_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_k   <= kmc_pkg::RST_CLUSTERS;
      cfg_d   <= kmc_pkg::RST_DIMS;
      cfg_n   <= kmc_pkg::RST_POINTS;
      cfg_thr <= kmc_pkg::RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        kmc_pkg::REG_CLUSTERS:  cfg_k   <= cfg_data[4:0];
        kmc_pkg::REG_DIMS:      cfg_d   <= cfg_data[3:0];
        kmc_pkg::REG_POINTS:    cfg_n   <= cfg_data[10:0];
        kmc_pkg::REG_THRESHOLD: cfg_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to 1..max, held as count minus one
  always_comb begin
    if (cfg_k == '0) k_m1 = '0;
    else if (cfg_k > 5'(kmc_pkg::MAX_CLUSTERS)) k_m1 = kmc_pkg::CI_W'(kmc_pkg::MAX_CLUSTERS - 1);
    else k_m1 = kmc_pkg::CI_W'(cfg_k - 5'd1);
    if (cfg_d == '0) d_m1 = '0;
    else if (cfg_d > 4'(kmc_pkg::MAX_DIMS)) d_m1 = kmc_pkg::DI_W'(kmc_pkg::MAX_DIMS - 1);
    else d_m1 = kmc_pkg::DI_W'(cfg_d - 4'd1);
    if (cfg_n == '0) n_m1 = '0;
    else if (cfg_n > 11'(kmc_pkg::MAX_POINTS)) n_m1 = kmc_pkg::PI_W'(kmc_pkg::MAX_POINTS - 1);
    else n_m1 = kmc_pkg::PI_W'(cfg_n - 11'd1);
  end

  // loop counters
  logic [kmc_pkg::CI_W-1:0] c;
  logic [kmc_pkg::DI_W-1:0] j;
  logic [kmc_pkg::PI_W-1:0] p;

  always_ff @(posedge clk) begin
    if (cmd.c_clr) c <= '0; else if (cmd.c_inc) c <= c + 1'b1;
    if (cmd.j_clr) j <= '0; else if (cmd.j_inc) j <= j + 1'b1;
    if (cmd.p_clr) p <= '0; else if (cmd.p_inc) p <= p + 1'b1;
  end

  // run bookkeeping
  logic                        ran;
  logic                        first_pass;
  logic [kmc_pkg::PI_W-1:0]    run_n_m1;
  logic [kmc_pkg::PROD_W-1:0]  thr_n;
  logic [kmc_pkg::PASS_W-1:0]  passes;
  logic [kmc_pkg::CNT_W-1:0]   changed;
  logic [kmc_pkg::CNT_W-1:0]   n_eff;

  assign n_eff = {1'b0, n_m1} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ran <= 1'b0;
    end else if (cmd.run_init) begin
      ran <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      run_n_m1   <= n_m1;
      thr_n      <= kmc_pkg::PROD_W'(cfg_thr) * kmc_pkg::PROD_W'(n_eff);
      passes     <= '0;
      first_pass <= 1'b1;
    end else begin
      if (cmd.pass_init) passes <= passes + 1'b1;
      if (cmd.pass_end) first_pass <= 1'b0;
    end
  end

  // point store, undefined until loaded
  logic signed [kmc_pkg::COORD_W-1:0] point_mem [2**PA_W];
  logic signed [kmc_pkg::COORD_W-1:0] pt_q;
  logic [PA_W-1:0]                    pt_raddr;

  always_comb begin
    if (cmd.seed_rd) pt_raddr = {kmc_pkg::PI_W'(c), j};
    else pt_raddr = {p, j};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) point_mem[{in_pi, in_di}] <= in_coord;
    if (cmd.seed_rd || cmd.dist_rd || cmd.sum_rd) pt_q <= point_mem[pt_raddr];
  end

  // centroid store with per-entry valid, empty entries read as zero
  logic signed [kmc_pkg::COORD_W-1:0] cent_mem [CE_N];
  logic [CE_N-1:0]                    cent_vld;
  logic signed [kmc_pkg::COORD_W-1:0] cent_q;
  logic                               cent_vq;
  logic signed [kmc_pkg::COORD_W-1:0] cent_rd;
  logic [CA_W-1:0]                    cent_raddr;
  logic signed [kmc_pkg::COORD_W-1:0] quotient;

  assign cent_raddr = cmd.host_rd ? {in_ci, in_di} : {c, j};
  assign cent_rd    = cent_vq ? cent_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.seed_wr) cent_mem[{c, j}] <= pt_q;
    else if (cmd.mean_wr) cent_mem[{c, j}] <= quotient;
    if (cmd.host_rd || cmd.dist_rd) begin
      cent_q  <= cent_mem[cent_raddr];
      cent_vq <= cent_vld[cent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cent_vld <= '0;
    end else if (cmd.seed_wr || cmd.mean_wr) begin
      cent_vld[{c, j}] <= 1'b1;
    end
  end

  // distance unit
  logic signed [kmc_pkg::COORD_W:0]     diff;
  logic signed [2*kmc_pkg::COORD_W+1:0] prod;
  logic [kmc_pkg::SQ_W-1:0]             sq;
  logic [kmc_pkg::DIST_W-1:0]           dsum;
  logic [kmc_pkg::DIST_W-1:0]           best;
  logic [kmc_pkg::CI_W-1:0]             best_c;

  assign diff = {cent_rd[kmc_pkg::COORD_W-1], cent_rd} - {pt_q[kmc_pkg::COORD_W-1], pt_q};
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (cmd.dist_sq) sq <= prod[kmc_pkg::SQ_W-1:0];
    if (cmd.dist_clr) dsum <= '0;
    else if (cmd.dist_acc) dsum <= dsum + kmc_pkg::DIST_W'(sq);
    if (cmd.best_upd && (c == '0 || dsum < best)) begin
      best   <= dsum;
      best_c <= c;
    end
  end

  // label store, assigned only below the point count of the last run
  logic [kmc_pkg::CI_W-1:0] label_mem [kmc_pkg::MAX_POINTS];
  logic [kmc_pkg::CI_W-1:0] lab_q;

  always_ff @(posedge clk) begin
    if (cmd.lbl_upd) label_mem[p] <= best_c;
    if (cmd.host_rd) lab_q <= label_mem[in_pi];
    else if (cmd.lbl_rd) lab_q <= label_mem[p];
  end

  // member counts and change count
  logic [kmc_pkg::CNT_W-1:0] counts [kmc_pkg::MAX_CLUSTERS];

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      changed <= '0;
      for (int i = 0; i < kmc_pkg::MAX_CLUSTERS; i++) counts[i] <= '0;
    end else if (cmd.lbl_upd) begin
      if (first_pass || lab_q != best_c) changed <= changed + 1'b1;
      counts[best_c] <= counts[best_c] + 1'b1;
    end
  end

  // coordinate sums, valid bits cleared at each pass start
  logic signed [kmc_pkg::SUM_W-1:0] sum_mem [CE_N];
  logic [CE_N-1:0]                  sum_vld;
  logic signed [kmc_pkg::SUM_W-1:0] sum_q;
  logic                             sum_vq;
  logic signed [kmc_pkg::SUM_W-1:0] sum_base;
  logic [CA_W-1:0]                  sum_raddr;

  assign sum_raddr = cmd.mean_rd ? {c, j} : {best_c, j};
  assign sum_base  = sum_vq ? sum_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.sum_wr) begin
      sum_mem[{best_c, j}] <= sum_base
        + {{(kmc_pkg::SUM_W-kmc_pkg::COORD_W){pt_q[kmc_pkg::COORD_W-1]}}, pt_q};
    end
    if (cmd.sum_rd || cmd.mean_rd) begin
      sum_q  <= sum_mem[sum_raddr];
      sum_vq <= sum_vld[sum_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.pass_init) begin
      sum_vld <= '0;
    end else if (cmd.sum_wr) begin
      sum_vld[{best_c, j}] <= 1'b1;
    end
  end

  logic div_done;

  kmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_base),
    .divisor  (counts[c]),
    .done     (div_done),
    .quotient (quotient)
  );

  // status to controller
  always_comb begin
    sts.j_last      = (j == d_m1);
    sts.c_last      = (c == k_m1);
    sts.p_last      = (p == run_n_m1);
    sts.cnt_zero    = (counts[c] == '0);
    sts.div_done    = div_done;
    sts.more_passes = (passes != kmc_pkg::PASS_LIMIT)
                   && ({changed, 16'b0} > thr_n);
  end

  // host read captures and result register
  logic [kmc_pkg::PI_W-1:0] h_pi;
  logic [kmc_pkg::CI_W-1:0] h_ci;
  logic [kmc_pkg::DI_W-1:0] h_di;

  always_ff @(posedge clk) begin
    if (cmd.host_rd) begin
      h_pi <= in_pi;
      h_ci <= in_ci;
      h_di <= in_di;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_value  <= '0;
      out_status <= kmc_pkg::ST_OK;
      case (cmd.out_sel)
        kmc_pkg::OUT_LABEL: begin
          if (h_pi > n_m1) out_status <= kmc_pkg::ST_RANGE;
          else if (!ran || h_pi > run_n_m1) out_status <= kmc_pkg::ST_UNASSIGNED;
          else out_value <= kmc_pkg::COORD_W'(lab_q);
        end
        kmc_pkg::OUT_CENT: begin
          if (h_ci > k_m1 || h_di > d_m1) out_status <= kmc_pkg::ST_RANGE;
          else out_value <= cent_rd;
        end
        kmc_pkg::OUT_RUN: out_value <= kmc_pkg::COORD_W'(passes);
        default: ;
      endcase
    end
  end

endmodule

// File: design/kmc_ctrl.sv
// sequencing state machine of the k-means engine
`timescale 1ns / 1ps
module kmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  kmc_pkg::opcode_t  opcode,
  output logic              m_tvalid,
  input  logic              m_tready,
  output kmc_pkg::cmd_t     cmd,
  input  kmc_pkg::sts_t     sts
);

  kmc_pkg::state_t state, state_next;
  logic            take;

  assign s_tready = (state == kmc_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kmc_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_ld) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kmc_pkg::S_IDLE: begin
        if (take) begin
          case (opcode)
            kmc_pkg::OP_RUN:        state_next = kmc_pkg::S_SEED_RD;
            kmc_pkg::OP_READ_LABEL: state_next = kmc_pkg::S_RD_LABEL;
            kmc_pkg::OP_READ_CENT:  state_next = kmc_pkg::S_RD_CENT;
            default:                state_next = kmc_pkg::S_IDLE;
          endcase
        end
      end
      kmc_pkg::S_RD_LABEL, kmc_pkg::S_RD_CENT: state_next = kmc_pkg::S_IDLE;
      kmc_pkg::S_SEED_RD: state_next = kmc_pkg::S_SEED_WR;
      kmc_pkg::S_SEED_WR: begin
        if (sts.j_last && sts.c_last) state_next = kmc_pkg::S_PASS_INIT;
        else state_next = kmc_pkg::S_SEED_RD;
      end
      kmc_pkg::S_PASS_INIT: state_next = kmc_pkg::S_DIST_RD;
      kmc_pkg::S_DIST_RD:   state_next = kmc_pkg::S_DIST_SQ;
      kmc_pkg::S_DIST_SQ:   state_next = kmc_pkg::S_DIST_ACC;
      kmc_pkg::S_DIST_ACC: begin
        state_next = sts.j_last ? kmc_pkg::S_BEST : kmc_pkg::S_DIST_RD;
      end
      kmc_pkg::S_BEST: begin
        state_next = sts.c_last ? kmc_pkg::S_LBL_RD : kmc_pkg::S_DIST_RD;
      end
      kmc_pkg::S_LBL_RD:  state_next = kmc_pkg::S_LBL_UPD;
      kmc_pkg::S_LBL_UPD: state_next = kmc_pkg::S_SUM_RD;
      kmc_pkg::S_SUM_RD:  state_next = kmc_pkg::S_SUM_WR;
      kmc_pkg::S_SUM_WR: begin
        if (!sts.j_last) state_next = kmc_pkg::S_SUM_RD;
        else if (sts.p_last) state_next = kmc_pkg::S_MEAN_START;
        else state_next = kmc_pkg::S_DIST_RD;
      end
      kmc_pkg::S_MEAN_START: begin
        state_next = sts.cnt_zero ? kmc_pkg::S_MEAN_NEXT : kmc_pkg::S_MEAN_RD;
      end
      kmc_pkg::S_MEAN_RD:  state_next = kmc_pkg::S_MEAN_DIV;
      kmc_pkg::S_MEAN_DIV: state_next = kmc_pkg::S_MEAN_WAIT;
      kmc_pkg::S_MEAN_WAIT: begin
        if (sts.div_done) begin
          state_next = sts.j_last ? kmc_pkg::S_MEAN_NEXT : kmc_pkg::S_MEAN_RD;
        end
      end
      kmc_pkg::S_MEAN_NEXT: begin
        state_next = sts.c_last ? kmc_pkg::S_CHECK : kmc_pkg::S_MEAN_START;
      end
      kmc_pkg::S_CHECK: begin
        state_next = sts.more_passes ? kmc_pkg::S_PASS_INIT : kmc_pkg::S_DONE;
      end
      kmc_pkg::S_DONE: state_next = kmc_pkg::S_IDLE;
      default: state_next = kmc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_sel = kmc_pkg::OUT_ZERO;
    case (state)
      kmc_pkg::S_IDLE: begin
        if (take) begin
          case (opcode)
            kmc_pkg::OP_LOAD: begin
              cmd.load_wr = 1'b1;
              cmd.out_ld  = 1'b1;
            end
            kmc_pkg::OP_RUN: begin
              cmd.run_init = 1'b1;
              cmd.c_clr    = 1'b1;
              cmd.j_clr    = 1'b1;
            end
            default: cmd.host_rd = 1'b1;
          endcase
        end
      end
      kmc_pkg::S_RD_LABEL: begin
        cmd.out_ld  = 1'b1;
        cmd.out_sel = kmc_pkg::OUT_LABEL;
      end
      kmc_pkg::S_RD_CENT: begin
        cmd.out_ld  = 1'b1;
        cmd.out_sel = kmc_pkg::OUT_CENT;
      end
      kmc_pkg::S_SEED_RD: cmd.seed_rd = 1'b1;
      kmc_pkg::S_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (sts.j_last) begin
          cmd.j_clr = 1'b1;
          cmd.c_inc = 1'b1;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      kmc_pkg::S_PASS_INIT: begin
        cmd.pass_init = 1'b1;
        cmd.p_clr     = 1'b1;
        cmd.c_clr     = 1'b1;
        cmd.j_clr     = 1'b1;
        cmd.dist_clr  = 1'b1;
      end
      kmc_pkg::S_DIST_RD: cmd.dist_rd = 1'b1;
      kmc_pkg::S_DIST_SQ: cmd.dist_sq = 1'b1;
      kmc_pkg::S_DIST_ACC: begin
        cmd.dist_acc = 1'b1;
        if (sts.j_last) cmd.j_clr = 1'b1;
        else cmd.j_inc = 1'b1;
      end
      kmc_pkg::S_BEST: begin
        cmd.best_upd = 1'b1;
        cmd.dist_clr = 1'b1;
        if (sts.c_last) cmd.c_clr = 1'b1;
        else cmd.c_inc = 1'b1;
      end
      kmc_pkg::S_LBL_RD:  cmd.lbl_rd  = 1'b1;
      kmc_pkg::S_LBL_UPD: cmd.lbl_upd = 1'b1;
      kmc_pkg::S_SUM_RD:  cmd.sum_rd  = 1'b1;
      kmc_pkg::S_SUM_WR: begin
        cmd.sum_wr = 1'b1;
        if (sts.j_last) begin
          cmd.j_clr = 1'b1;
          cmd.c_clr = 1'b1;
          if (!sts.p_last) cmd.p_inc = 1'b1;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      kmc_pkg::S_MEAN_START: cmd.j_clr     = 1'b1;
      kmc_pkg::S_MEAN_RD:    cmd.mean_rd   = 1'b1;
      kmc_pkg::S_MEAN_DIV:   cmd.div_start = 1'b1;
      kmc_pkg::S_MEAN_WAIT: begin
        if (sts.div_done) begin
          cmd.mean_wr = 1'b1;
          if (!sts.j_last) cmd.j_inc = 1'b1;
        end
      end
      kmc_pkg::S_MEAN_NEXT: begin
        if (!sts.c_last) cmd.c_inc = 1'b1;
      end
      kmc_pkg::S_CHECK: cmd.pass_end = 1'b1;
      kmc_pkg::S_DONE: begin
        cmd.out_ld  = 1'b1;
        cmd.out_sel = kmc_pkg::OUT_RUN;
      end
      default: ;
    endcase
  end

  // only an idle controller takes requests
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == kmc_pkg::S_IDLE)
    else $error("request taken outside idle");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // the mean step waits for the divider
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == kmc_pkg::S_MEAN_WAIT && !sts.div_done) |=> state == kmc_pkg::S_MEAN_WAIT)
    else $error("mean step left before divide finished");

  // the run result follows only a finished convergence check
  a_done_order: assert property (@(posedge clk) disable iff (rst)
    state == kmc_pkg::S_DONE |-> $past(state) == kmc_pkg::S_CHECK)
    else $error("run result without convergence check");

endmodule

// File: design/kmeans_clustering_engine.sv
// top level of the lloyd k-means clustering engine
`timescale 1ns / 1ps
// Lloyd k-means engine over up to 1024 points of up to 8 signed 16-bit
// coordinates and up to 16 clusters. Load and label/centroid read requests
// use s_tuser as the opcode. A load can be issued every cycle unless
// m_tready holds back a waiting result; a read goes through a registered
// memory read, then the result register. A run request seeds the
// centroids from the first K points and iterates passes until the fraction
// of changed labels is at or below the Q0.16 threshold or 32767 passes are
// done; s_tready stays low meanwhile. Each pass runs the distance search,
// label and sum update (one shared 17x17 squarer, one read port on each
// store), then the means on the bit-serial 26-step divider.
// No clearing pass runs after reset.
// The result channel has one output register, so a new request is taken
// in the same cycle that a waiting result is taken.
module kmeans_clustering_engine (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // point_index, cluster_index, dim_index, coord_value, zero pad
  input  logic [1:0]  s_tuser,  // opcode
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // result_value
  output logic [1:0]  m_tuser,  // status
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  kmc_pkg::cmd_t                      cmd;
  kmc_pkg::sts_t                      sts;
  logic signed [kmc_pkg::COORD_W-1:0] out_value;
  kmc_pkg::status_t                   out_status;
  kmc_pkg::opcode_t                   opcode;

  assign opcode  = kmc_pkg::opcode_t'(s_tuser);
  assign m_tdata = out_value;
  assign m_tuser = out_status;

  kmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (opcode),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // request fields unpacked from tdata, lowest bits first
  kmc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_pi      (s_tdata[9:0]),
    .in_ci      (s_tdata[13:10]),
    .in_di      (s_tdata[16:14]),
    .in_coord   (s_tdata[32:17]),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

// File: dv/testbench.sv
// self-checking testbench for the k-means clustering engine
`timescale 1ns / 1ps

import kmc_pkg::*;

typedef struct packed {
  logic [15:0] value;
  logic [1:0]  status;
} kmc_result_t;

// holds the expected results in order and compares each one that arrives
class result_board;
  kmc_result_t awaited[$];
  int          errors = 0;
  int          checked = 0;

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function void note_request(kmc_result_t r);
    awaited.insert(awaited.size(), r);
  endfunction

  task check_result(logic [15:0] value, logic [1:0] status);
    kmc_result_t want;
    if (awaited.size() == 0) begin
      report($sformatf("unexpected result value %h status %0d", value, status));
    end else begin
      want = awaited.pop_front();
      checked++;
      if (value !== want.value)
        report($sformatf("result value %h, expected %h", value, want.value));
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
    end
  endtask

  function int pending();
    return awaited.size();
  endfunction
endclass

module testbench;

  // cycles with no handshake before giving up
  localparam int QUIET_LIMIT = 2000000000;
  localparam int ITEM_GOAL   = 1250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  kmeans_clustering_engine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  result_board board = new();

  // idling knobs, percent of cycles
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;

  // run statistics
  int unsigned n_items = 0, n_runs = 0, n_loads = 0, n_reads = 0, max_passes = 0;
  int unsigned quiet = 0;

  // predictor copy of the engine state
  logic [4:0]         k_reg = RST_CLUSTERS;
  logic [3:0]         d_reg = RST_DIMS;
  logic [10:0]        n_reg = RST_POINTS;
  logic [15:0]        thr_reg = RST_THRESHOLD;
  logic signed [15:0] coord_mem [0:MAX_POINTS*MAX_DIMS-1];
  bit                 coord_known [0:MAX_POINTS*MAX_DIMS-1];
  logic [4:0]         label_mem [0:MAX_POINTS-1];
  logic signed [15:0] cent_mem [0:MAX_CLUSTERS*MAX_DIMS-1];

  localparam logic [4:0] NO_LABEL = 5'h1f;

  initial begin
    for (int i = 0; i < MAX_POINTS*MAX_DIMS; i++) begin
      coord_mem[i] = '0;
      coord_known[i] = 1'b0;
    end
    for (int i = 0; i < MAX_POINTS; i++) label_mem[i] = NO_LABEL;
    for (int i = 0; i < MAX_CLUSTERS*MAX_DIMS; i++) cent_mem[i] = '0;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_k();
    return clamp_to(k_reg, MAX_CLUSTERS);
  endfunction

  function automatic int unsigned eff_d();
    return clamp_to(d_reg, MAX_DIMS);
  endfunction

  function automatic int unsigned eff_n();
    return clamp_to(n_reg, MAX_POINTS);
  endfunction

  // a run may only touch coordinates that were loaded
  function automatic bit run_allowed();
    int unsigned k, d, n, span;
    k = eff_k();
    d = eff_d();
    n = eff_n();
    span = (n > k) ? n : k;
    for (int unsigned p = 0; p < span; p++)
      for (int unsigned j = 0; j < d; j++)
        if (!coord_known[p*MAX_DIMS + j]) return 1'b0;
    return 1'b1;
  endfunction

  // lloyd iterations: seed, assign, average, repeat until the change ratio is low
  function automatic int unsigned cluster_points();
    int unsigned k, d, n, passes, changed, best_c;
    longint      best, dsq, diff;
    longint      sums [0:MAX_CLUSTERS*MAX_DIMS-1];
    int unsigned members [0:MAX_CLUSTERS-1];
    k = eff_k();
    d = eff_d();
    n = eff_n();
    passes = 0;
    for (int unsigned c = 0; c < k; c++)
      for (int unsigned j = 0; j < d; j++)
        cent_mem[c*MAX_DIMS + j] = coord_mem[c*MAX_DIMS + j];
    for (int i = 0; i < MAX_POINTS; i++) label_mem[i] = NO_LABEL;
    do begin
      for (int i = 0; i < MAX_CLUSTERS*MAX_DIMS; i++) sums[i] = 0;
      for (int i = 0; i < MAX_CLUSTERS; i++) members[i] = 0;
      changed = 0;
      for (int unsigned p = 0; p < n; p++) begin
        best = 0;
        best_c = 0;
        for (int unsigned c = 0; c < k; c++) begin
          dsq = 0;
          for (int unsigned j = 0; j < d; j++) begin
            diff = longint'(cent_mem[c*MAX_DIMS + j]) - longint'(coord_mem[p*MAX_DIMS + j]);
            dsq += diff * diff;
          end
          // strict compare keeps the lowest index on ties
          if (c == 0 || dsq < best) begin
            best = dsq;
            best_c = c;
          end
        end
        if (label_mem[p] != best_c[4:0]) changed++;
        label_mem[p] = best_c[4:0];
        for (int unsigned j = 0; j < d; j++)
          sums[best_c*MAX_DIMS + j] += longint'(coord_mem[p*MAX_DIMS + j]);
        members[best_c]++;
      end
      // empty clusters keep their centroid
      for (int unsigned c = 0; c < k; c++)
        if (members[c] != 0)
          for (int unsigned j = 0; j < d; j++)
            cent_mem[c*MAX_DIMS + j] = 16'(sums[c*MAX_DIMS + j] / longint'(members[c]));
      passes++;
    end while (passes < 32767 && longint'(changed) * 65536 > longint'(thr_reg) * n);
    return passes;
  endfunction

  function automatic kmc_result_t predict_result(opcode_t op, logic [9:0] pi, logic [3:0] ci,
                                                 logic [2:0] di, logic [15:0] cv);
    kmc_result_t r;
    int unsigned passes;
    r.value = '0;
    r.status = ST_OK;
    case (op)
      OP_LOAD: begin
        coord_mem[pi*MAX_DIMS + di] = cv;
        coord_known[pi*MAX_DIMS + di] = 1'b1;
      end
      OP_RUN: begin
        passes = cluster_points();
        if (passes > max_passes) max_passes = passes;
        r.value = 16'(passes);
      end
      OP_READ_LABEL: begin
        if (pi >= eff_n()) r.status = ST_RANGE;
        else if (label_mem[pi] == NO_LABEL) r.status = ST_UNASSIGNED;
        else r.value = 16'(label_mem[pi]);
      end
      default: begin
        if (ci >= eff_k() || di >= eff_d()) r.status = ST_RANGE;
        else r.value = cent_mem[ci*MAX_DIMS + di];
      end
    endcase
    return r;
  endfunction

  // drive one request and wait for the handshake; called right after a rising edge
  task automatic send_req(opcode_t op, logic [9:0] pi, logic [3:0] ci, logic [2:0] di,
                          logic [15:0] cv);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, cv, di, ci, pi};
    do @(posedge clk); while (!s_tready);
    board.note_request(predict_result(op, pi, ci, di, cv));
    n_items++;
    case (op)
      OP_LOAD: n_loads++;
      OP_RUN:  n_runs++;
      default: n_reads++;
    endcase
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // register write; the caller lowers cfg_we after its last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_CLUSTERS: k_reg = val[4:0];
      REG_DIMS:     d_reg = val[3:0];
      REG_POINTS:   n_reg = val[10:0];
      default:      thr_reg = val;
    endcase
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random request of any kind; runs only when every needed point is loaded
  task automatic send_noise();
    opcode_t op;
    op = opcode_t'($urandom_range(3));
    if (op == OP_RUN && !run_allowed()) op = OP_READ_LABEL;
    send_req(op, 10'($urandom), 4'($urandom), 3'($urandom), 16'($urandom));
  endtask

  // one configuration, a data set loaded for it when small enough, a run when all its points are loaded, and reads
  task automatic run_sequence(int unsigned seq);
    int unsigned kr, dr, nr, tr, k, d, n, span, style, grp;
    logic [15:0] centers [0:3][0:7];
    logic [15:0] cv;
    case (seq % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 47; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 47; end
      default: begin send_idle = 16; recv_stall = 16; end
    endcase
    drain();
    case ($urandom_range(9))
      0: kr = 0;
      1: kr = 16;
      2: kr = 17;
      3: kr = 31;
      default: kr = $urandom_range(1, 5);
    endcase
    case ($urandom_range(9))
      0: dr = 0;
      1: dr = 8;
      2: dr = 9;
      3: dr = 15;
      default: dr = $urandom_range(1, 4);
    endcase
    case ($urandom_range(11))
      0: nr = 0;
      1: nr = 1024;
      2: nr = 2047;
      3: nr = 1025;
      default: nr = $urandom_range(1, 12);
    endcase
    case ($urandom_range(5))
      0: tr = 0;
      1: tr = 65535;
      2: tr = 3277;
      default: tr = $urandom_range(0, 20000);
    endcase
    write_reg(REG_CLUSTERS, 16'(kr));
    write_reg(REG_DIMS, 16'(dr));
    write_reg(REG_POINTS, 16'(nr));
    write_reg(REG_THRESHOLD, 16'(tr));
    end_writes();
    k = eff_k();
    d = eff_d();
    n = eff_n();
    span = (n > k) ? n : k;
    style = $urandom_range(7);
    for (int g = 0; g < 4; g++)
      for (int j = 0; j < 8; j++)
        centers[g][j] = 16'($urandom_range(0, 60000) - 30000);
    // load a fresh data set: mostly grouped points, sometimes full-range values
    if (span * d <= 200) begin
      for (int unsigned p = 0; p < span; p++) begin
        grp = $urandom_range(3);
        for (int unsigned j = 0; j < d; j++) begin
          case (style)
            0: cv = 16'($urandom);
            1: cv = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            2: cv = 16'($urandom_range(0, 6));
            default: cv = centers[grp][j] + 16'($urandom_range(0, 512) - 256);
          endcase
          send_req(OP_LOAD, 10'(p), 4'($urandom), 3'(j), cv);
        end
      end
    end
    repeat (3) send_noise();
    if (run_allowed()) send_req(OP_RUN, 10'($urandom), 4'($urandom), 3'($urandom), 16'($urandom));
    repeat (8) send_req(OP_READ_LABEL, 10'($urandom_range(0, n + 1)), 4'($urandom),
                        3'($urandom), 16'($urandom));
    repeat (6) send_req(OP_READ_CENT, 10'($urandom),
                        4'($urandom_range(0, (k < 15) ? k : 15)),
                        3'($urandom_range(0, (d < 7) ? d : 7)), 16'($urandom));
    repeat (3) send_noise();
  endtask

  // result side: random back-pressure, checking, and the no-progress watchdog
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      quiet <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= recv_stall);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("kmeans_clustering_engine regression: fail");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int unsigned seq;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, store edges, field extremes
    send_req(OP_READ_LABEL, 10'd0, 4'd0, 3'd0, 16'h0000);     // never labelled
    send_req(OP_READ_LABEL, 10'd1023, 4'd0, 3'd0, 16'h0000);  // last point, unlabelled
    send_req(OP_READ_CENT, 10'd0, 4'd1, 3'd1, 16'h0000);      // reset centroid
    send_req(OP_READ_CENT, 10'd0, 4'd2, 3'd0, 16'h0000);      // cluster past K
    send_req(OP_READ_CENT, 10'd0, 4'd0, 3'd2, 16'h0000);      // coordinate past D
    send_req(OP_READ_CENT, 10'd1023, 4'd15, 3'd7, 16'hffff);
    send_req(OP_LOAD, 10'd1023, 4'd15, 3'd7, 16'h5555);
    send_req(OP_LOAD, 10'd0, 4'd0, 3'd0, 16'h8000);
    send_req(OP_LOAD, 10'd0, 4'd0, 3'd1, 16'h7fff);
    send_req(OP_LOAD, 10'd1, 4'd0, 3'd0, 16'h7fff);
    send_req(OP_LOAD, 10'd1, 4'd0, 3'd1, 16'h8000);
    send_req(OP_LOAD, 10'd2, 4'd0, 3'd0, 16'h7ff0);
    send_req(OP_LOAD, 10'd2, 4'd0, 3'd1, 16'h8010);
    send_req(OP_LOAD, 10'd3, 4'd0, 3'd0, 16'h0000);
    send_req(OP_LOAD, 10'd3, 4'd0, 3'd1, 16'h0000);
    drain();
    write_reg(REG_POINTS, 16'd4);
    write_reg(REG_THRESHOLD, 16'd0);
    end_writes();
    send_req(OP_RUN, 10'd0, 4'd0, 3'd0, 16'h0000);
    send_req(OP_READ_LABEL, 10'd2, 4'd0, 3'd0, 16'h0000);
    send_req(OP_READ_LABEL, 10'd3, 4'd0, 3'd0, 16'h0000);
    send_req(OP_READ_LABEL, 10'd4, 4'd0, 3'd0, 16'h0000);    // point past N
    send_req(OP_READ_CENT, 10'd0, 4'd1, 3'd1, 16'h0000);
    // more clusters than points: seeding still reads point 2
    drain();
    write_reg(REG_POINTS, 16'd2);
    write_reg(REG_CLUSTERS, 16'd3);
    end_writes();
    send_req(OP_RUN, 10'd0, 4'd0, 3'd0, 16'h0000);
    send_req(OP_READ_CENT, 10'd0, 4'd2, 3'd1, 16'h0000);     // empty cluster keeps seed
    send_req(OP_READ_LABEL, 10'd1, 4'd0, 3'd0, 16'h0000);

    // random sequences across all idling modes
    seq = 0;
    while (n_items < ITEM_GOAL) begin
      run_sequence(seq);
      seq++;
    end

    drain();
    repeat (64) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    $display("covered %0d requests: %0d loads, %0d reads, %0d runs (up to %0d passes)",
             n_items, n_loads, n_reads, n_runs, max_passes);
    $display("%0d results checked, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("kmeans_clustering_engine regression: pass");
    end else begin
      $display("kmeans_clustering_engine regression: fail");
    end
    $finish;
  end

endmodule
